>>> hdl/ptab_pkg.sv
// ----------------------------------------------------------------------------
// ptab_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package ptab_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FLAGS_W    = 12;
  localparam int unsigned PAGE_OFS_W = 12;
  localparam int unsigned DIR_IDX_W  = 10;
  localparam int unsigned TBL_IDX_W  = 10;
  localparam int unsigned DIR_DEPTH  = 1 << DIR_IDX_W;
  localparam int unsigned TBL_DEPTH  = 1 << (DIR_IDX_W + TBL_IDX_W);
  localparam int unsigned STATUS_W   = 3;

  // Directory entry flags: present and writable.
  localparam logic [ADDR_W-1:0] DIR_FLAGS = ADDR_W'(32'h3);

  typedef enum logic [0:0] {
    OP_MAP    = 1'b0,
    OP_LOOKUP = 1'b1
  } ptab_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_MISALIGNED  = 3'd1,
    STAT_PRESENT     = 3'd2,
    STAT_NO_TABLE    = 3'd3,
    STAT_NOT_MAPPED  = 3'd4
  } ptab_status_e;

  typedef enum logic [2:0] {
    PS_INIT,
    PS_IDLE,
    PS_EVAL,
    PS_CLEAR,
    PS_FINISH
  } ptab_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         capture;     // take the item and read both memories
    logic         dir_clr;     // write zero to directory slot at the counter
    logic         dir_new;     // create the directory slot of the item
    logic         tbl_wr;      // write the item's page entry
    logic         tbl_clr;     // write one entry of the new table
    logic         cnt_inc;     // advance the sweep counter
    logic         load_out;    // load the result register
    ptab_status_e out_status;
    logic         out_frame;   // result address is the looked-up frame
  } ptab_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    ptab_op_e op;
    logic     va_misal;
    logic     pa_misal;
    logic     tpage_zero;
    logic     override;
    logic     dir_present;
    logic     ent_present;
    logic     cnt_last;
    logic     out_free;
  } ptab_stat_t;

endpackage

>>> hdl/ptab_if.sv
// ----------------------------------------------------------------------------
// ptab_if
// Request and response channels of the page table engine.
// ----------------------------------------------------------------------------
interface ptab_req_if;
  logic                            valid;
  logic                            ready;
  logic [0:0]                      operation;
  logic [ptab_pkg::ADDR_W-1:0]     virt_addr;
  logic [ptab_pkg::ADDR_W-1:0]     phys_addr;
  logic [ptab_pkg::FLAGS_W-1:0]    page_flags;
  logic [0:0]                      override;
  logic [ptab_pkg::ADDR_W-1:0]     table_page_addr;

  modport source (output valid, operation, virt_addr, phys_addr, page_flags,
                  override, table_page_addr, input ready);
  modport sink   (input valid, operation, virt_addr, phys_addr, page_flags,
                  override, table_page_addr, output ready);
endinterface

interface ptab_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ptab_pkg::STATUS_W-1:0]   status;
  logic [ptab_pkg::ADDR_W-1:0]     result_addr;

  modport source (output valid, status, result_addr, input ready);
  modport sink   (input valid, status, result_addr, output ready);
endinterface

>>> hdl/ptab_dp.sv
// ----------------------------------------------------------------------------
// ptab_dp
// Datapath: item register, directory and table memories, sweep counter and
// result register.
// ----------------------------------------------------------------------------
module ptab_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [0:0]                   operation_i,
  input  logic [ptab_pkg::ADDR_W-1:0]  virt_addr_i,
  input  logic [ptab_pkg::ADDR_W-1:0]  phys_addr_i,
  input  logic [ptab_pkg::FLAGS_W-1:0] page_flags_i,
  input  logic [0:0]                   override_i,
  input  logic [ptab_pkg::ADDR_W-1:0]  table_page_addr_i,
  input  ptab_pkg::ptab_cmd_t          cmd_i,
  output ptab_pkg::ptab_stat_t         stat_o,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [ptab_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [ptab_pkg::ADDR_W-1:0]  rsp_addr_o
);
  import ptab_pkg::*;

  localparam int unsigned VA_DIR_LSB = PAGE_OFS_W + TBL_IDX_W;

  logic [ADDR_W-1:0]    dir_mem [DIR_DEPTH];
  logic [ADDR_W-1:0]    tbl_mem [TBL_DEPTH];

  logic [0:0]           op_q;
  logic [ADDR_W-1:0]    va_q;
  logic [ADDR_W-1:0]    pa_q;
  logic [FLAGS_W-1:0]   flags_q;
  logic [0:0]           ovr_q;
  logic [ADDR_W-1:0]    tpage_q;
  logic [ADDR_W-1:0]    dir_ent_q;
  logic [ADDR_W-1:0]    tbl_ent_q;
  logic [TBL_IDX_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  ptab_status_e         out_status_q;
  logic [ADDR_W-1:0]    out_addr_q;

  logic [DIR_IDX_W-1:0] dslot;
  logic [TBL_IDX_W-1:0] eslot;
  logic [ADDR_W-1:0]    new_entry;

  assign dslot     = va_q[ADDR_W-1:VA_DIR_LSB];
  assign eslot     = va_q[VA_DIR_LSB-1:PAGE_OFS_W];
  assign new_entry = pa_q | {{(ADDR_W-FLAGS_W){1'b0}}, flags_q};

  // Item register, captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      va_q    <= virt_addr_i;
      pa_q    <= phys_addr_i;
      flags_q <= page_flags_i;
      ovr_q   <= override_i;
      tpage_q <= table_page_addr_i;
    end
  end

  // Directory memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.dir_clr) begin
      dir_mem[cnt_q] <= '0;
    end else if (cmd_i.dir_new) begin
      dir_mem[dslot] <= tpage_q | DIR_FLAGS;
    end
    if (cmd_i.capture) begin
      dir_ent_q <= dir_mem[virt_addr_i[ADDR_W-1:VA_DIR_LSB]];
    end
  end

  // Table memory. During a clear the item's own entry is written with the
  // new page entry, every other entry with zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_clr) begin
      tbl_mem[{dslot, cnt_q}] <= (cnt_q == eslot) ? new_entry : '0;
    end else if (cmd_i.tbl_wr) begin
      tbl_mem[{dslot, eslot}] <= new_entry;
    end
    if (cmd_i.capture) begin
      tbl_ent_q <= tbl_mem[virt_addr_i[ADDR_W-1:PAGE_OFS_W]];
    end
  end

  assign cnt_d = cmd_i.cnt_inc ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_addr_q   <= cmd_i.out_frame ? {tbl_ent_q[ADDR_W-1:PAGE_OFS_W],
                                         {PAGE_OFS_W{1'b0}}} : '0;
    end
  end

  always_comb begin
    stat_o.op          = ptab_op_e'(op_q);
    stat_o.va_misal    = |va_q[PAGE_OFS_W-1:0];
    stat_o.pa_misal    = |pa_q[PAGE_OFS_W-1:0];
    stat_o.tpage_zero  = (tpage_q == '0);
    stat_o.override    = ovr_q[0];
    stat_o.dir_present = dir_ent_q[0];
    stat_o.ent_present = tbl_ent_q[0];
    stat_o.cnt_last    = &cnt_q;
    stat_o.out_free    = !out_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_addr_o   = out_addr_q;

endmodule

>>> hdl/ptab_ctrl.sv
// ----------------------------------------------------------------------------
// ptab_ctrl
// Controller: sequences reset sweep, item evaluation and table clears.
// ----------------------------------------------------------------------------
module ptab_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ptab_pkg::ptab_stat_t  stat_i,
  output ptab_pkg::ptab_cmd_t   cmd_o
);
  import ptab_pkg::*;

  ptab_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      PS_INIT: begin
        if (stat_i.cnt_last) state_d = PS_IDLE;
      end
      PS_IDLE: begin
        if (req_valid_i) state_d = PS_EVAL;
      end
      PS_EVAL: begin
        if (stat_i.op == OP_MAP && !stat_i.va_misal && !stat_i.pa_misal &&
            !stat_i.dir_present && !stat_i.tpage_zero) begin
          state_d = PS_CLEAR;
        end else if (stat_i.out_free) begin
          state_d = PS_IDLE;
        end
      end
      PS_CLEAR: begin
        if (stat_i.cnt_last) state_d = PS_FINISH;
      end
      PS_FINISH: begin
        if (stat_i.out_free) state_d = PS_IDLE;
      end
      default: state_d = PS_INIT;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = STAT_OK;
    req_ready_o      = 1'b0;
    case (state_q)
      PS_INIT: begin
        cmd_o.dir_clr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      PS_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      PS_EVAL: begin
        if (stat_i.op == OP_LOOKUP) begin
          cmd_o.load_out = stat_i.out_free;
          if (stat_i.va_misal || !stat_i.dir_present || !stat_i.ent_present) begin
            cmd_o.out_status = STAT_NOT_MAPPED;
          end else begin
            cmd_o.out_frame = 1'b1;
          end
        end else if (stat_i.va_misal || stat_i.pa_misal) begin
          cmd_o.load_out   = stat_i.out_free;
          cmd_o.out_status = STAT_MISALIGNED;
        end else if (!stat_i.dir_present) begin
          if (stat_i.tpage_zero) begin
            cmd_o.load_out   = stat_i.out_free;
            cmd_o.out_status = STAT_NO_TABLE;
          end else begin
            cmd_o.dir_new = 1'b1;
          end
        end else if (stat_i.ent_present && !stat_i.override) begin
          cmd_o.load_out   = stat_i.out_free;
          cmd_o.out_status = STAT_PRESENT;
        end else begin
          cmd_o.load_out = stat_i.out_free;
          cmd_o.tbl_wr   = stat_i.out_free;
        end
      end
      PS_CLEAR: begin
        cmd_o.tbl_clr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      PS_FINISH: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> hdl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// Maps pages into and looks up addresses in a 32-bit two-level page table.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake      Carries
//  req_i    in         valid/ready    operation, virt_addr, phys_addr,
//                                     page_flags, override, table_page_addr
//  rsp_o    out        valid/ready    status, result_addr
//
// An ordinary map or lookup reads both memories as the item is taken in
// PS_IDLE; PS_EVAL then decides, writes the page entry of a map and loads
// the result, waiting while the output register is full. A map that creates
// a new table first writes its directory slot, then clears all 1024 entries
// of the table in PS_CLEAR, one entry per cycle through the single write port
// of the table memory, and loads the result in PS_FINISH. After reset the
// block sweeps all 1024 directory slots to zero, taking no item meanwhile.
// A result waits in the output register; the next item is taken meanwhile,
// and the block only stalls when a second result would overwrite it.
// ----------------------------------------------------------------------------
module two_level_page_table_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptab_req_if.sink   req_i,
  ptab_rsp_if.source rsp_o
);
  import ptab_pkg::*;

  ptab_cmd_t  cmd;
  ptab_stat_t stat;

  // The controller sequences the work; the datapath holds all storage.
  ptab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptab_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (req_i.operation),
    .virt_addr_i       (req_i.virt_addr),
    .phys_addr_i       (req_i.phys_addr),
    .page_flags_i      (req_i.page_flags),
    .override_i        (req_i.override),
    .table_page_addr_i (req_i.table_page_addr),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_addr_o        (rsp_o.result_addr)
  );

  // A result is loaded only when the output register is free.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending result");

  // Only one item is in work at a time.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("item accepted while another is in work");

  // A directory slot is created only when it is absent.
  a_new_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dir_new |-> !stat.dir_present)
    else $error("directory slot created over a present slot");

endmodule
